// ===== sv/hmb_pkg.sv =====
package hmb_pkg;

	// Default sizes
	localparam int MAX_BLUR_DEF     = 32;
	localparam int CHANNEL_BITS_DEF = 8;

	// Width of the blur amount register
	localparam int BLUR_W = 6;

	// Colour channels: 0 red, 1 green, 2 blue
	localparam int NUM_CH = 3;

	// Controller states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_DECIDE = 7'b0000010,
		ST_OLD    = 7'b0000100,
		ST_SWEEP  = 7'b0001000,
		ST_MUL    = 7'b0010000,
		ST_DIV    = 7'b0100000,
		ST_OUT    = 7'b1000000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_item; // write incoming pixel, update count and sums
		logic start;     // latch window length, read oldest pixel
		logic cap_old;   // capture oldest pixel, take window sum from totals
		logic sweep;     // walk the store to sum a short window
		logic mul;       // form numerators and divisor
		logic div;       // one restoring division step
		logic out_load;  // load output register, drop oldest pixel
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic emit;       // an output is due
		logic use_total;  // window covers every remaining pixel
		logic sweep_done; // window sum complete
		logic div_done;   // last division step this cycle
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

// ===== sv/horizontal_motion_blur.sv =====
// Sequence: an output follows its pixel's transfer through the decide, old-pixel, multiply,
// division and output states, plus a window store sweep after the blur amount is lowered mid row.
// An item is taken only in the idle state, so no new item enters while outputs are being formed;
// the pace is set by the shared bit-per-cycle divider and the single port of the window store.
// Reset (arst_n low, asynchronous): store empty, running sums and blur amount zero, no output valid;
// the window store contents are not cleared.
module horizontal_motion_blur #(
	parameter int MAX_BLUR     = hmb_pkg::MAX_BLUR_DEF,
	parameter int CHANNEL_BITS = hmb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [hmb_pkg::BLUR_W-1:0] blur_amount,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [CHANNEL_BITS-1:0]    red_in,
	input  logic [CHANNEL_BITS-1:0]    green_in,
	input  logic [CHANNEL_BITS-1:0]    blue_in,
	input  logic                       row_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [CHANNEL_BITS-1:0]    red_out,
	output logic [CHANNEL_BITS-1:0]    green_out,
	output logic [CHANNEL_BITS-1:0]    blue_out,
	output logic                       row_done
);

	hmb_pkg::cmd_t cmd;
	hmb_pkg::sts_t sts;

	// Register writes must arrive only while idle; the block itself does not enforce this
	assign cfg_ready = 1'b1;

	// Sequencer
	hmb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Window store, sums, divider and output register
	hmb_datapath #(
		.MAX_BLUR     (MAX_BLUR),
		.CHANNEL_BITS (CHANNEL_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_valid   (cfg_valid),
		.blur_amount (blur_amount),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.row_end     (row_end),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.row_done    (row_done)
	);

endmodule

// ===== sv/hmb_ctrl.sv =====
module hmb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  hmb_pkg::sts_t sts,
	output hmb_pkg::cmd_t cmd
);

	hmb_pkg::state_t state_q;
	hmb_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hmb_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			hmb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_nxt     = hmb_pkg::ST_DECIDE;
				end
			end
			hmb_pkg::ST_DECIDE: begin
				if (sts.emit) begin
					cmd.start = 1'b1;
					state_nxt = hmb_pkg::ST_OLD;
				end else begin
					state_nxt = hmb_pkg::ST_IDLE;
				end
			end
			hmb_pkg::ST_OLD: begin
				cmd.cap_old = 1'b1;
				state_nxt   = sts.use_total ? hmb_pkg::ST_MUL : hmb_pkg::ST_SWEEP;
			end
			hmb_pkg::ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_done) begin
					state_nxt = hmb_pkg::ST_MUL;
				end
			end
			hmb_pkg::ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = hmb_pkg::ST_DIV;
			end
			hmb_pkg::ST_DIV: begin
				cmd.div = 1'b1;
				if (sts.div_done) begin
					state_nxt = hmb_pkg::ST_OUT;
				end
			end
			hmb_pkg::ST_OUT: begin
				// wait for the output register, then drop the oldest pixel
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = hmb_pkg::ST_DECIDE;
				end
			end
			default: begin
				state_nxt = hmb_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== sv/hmb_datapath.sv =====
module hmb_datapath #(
	parameter int MAX_BLUR     = hmb_pkg::MAX_BLUR_DEF,
	parameter int CHANNEL_BITS = hmb_pkg::CHANNEL_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  hmb_pkg::cmd_t              cmd,
	output hmb_pkg::sts_t              sts,
	input  logic                       cfg_valid,
	input  logic [hmb_pkg::BLUR_W-1:0] blur_amount,
	input  logic [CHANNEL_BITS-1:0]    red_in,
	input  logic [CHANNEL_BITS-1:0]    green_in,
	input  logic [CHANNEL_BITS-1:0]    blue_in,
	input  logic                       row_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [CHANNEL_BITS-1:0]    red_out,
	output logic [CHANNEL_BITS-1:0]    green_out,
	output logic [CHANNEL_BITS-1:0]    blue_out,
	output logic                       row_done
);

	localparam int CB    = CHANNEL_BITS;
	localparam int NCH   = hmb_pkg::NUM_CH;
	localparam int BW    = hmb_pkg::BLUR_W;
	localparam int DEPTH = MAX_BLUR + 1;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(MAX_BLUR + 2);
	localparam int FW    = $clog2(MAX_BLUR + 1);
	localparam int SW    = CB + CW;
	localparam int NW    = CB + FW + 1;
	localparam int DW    = FW + 1;
	localparam int KW    = $clog2(CB + 1);

	typedef logic [NCH-1:0][CB-1:0] pix_t;

	// Window store and its read register
	pix_t mem [DEPTH];
	pix_t rd_data_q;

	// Control state
	logic [BW-1:0] blur_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic          last_q;
	logic [CW-1:0] off_q;
	logic          rvld_q;
	logic [KW-1:0] step_q;
	logic          out_valid_q;

	// Payload state
	logic [NCH-1:0][SW-1:0] tot_q;
	logic [NCH-1:0][SW-1:0] acc_q;
	logic [NCH-1:0][NW-1:0] num_q;
	pix_t                   old_q;
	pix_t                   quo_q;
	pix_t                   out_q;
	logic [NW-1:0]          dsh_q;
	logic [FW-1:0]          follow_q;
	logic                   done_q;
	logic                   use_total_q;
	logic                   out_done_q;

	// Combinational helpers
	pix_t                      in_pix;
	logic [BW-1:0]             n_clamp;
	logic [FW-1:0]             n_f;
	logic [CW-1:0]             count_m1;
	logic [FW-1:0]             follow_c;
	logic                      emit_c;
	logic                      issue;
	logic [PW:0]               sw_sum;
	logic [PW-1:0]             sw_addr;
	logic [PW-1:0]             rd_addr;
	logic                      rd_en;
	logic [DW-1:0]             divisor;
	logic [NCH-1:0][FW+CB-1:0] prod;
	logic [NCH-1:0]            qbit;

	assign in_pix = {blue_in, green_in, red_in};

	// Window length for the next output
	assign n_clamp  = (blur_q > BW'(MAX_BLUR)) ? BW'(MAX_BLUR) : blur_q;
	assign n_f      = FW'(n_clamp);
	assign count_m1 = count_q - CW'(1);
	assign follow_c = last_q ? FW'(count_m1) : n_f;
	assign emit_c   = last_q ? (count_q != '0) : (count_q > CW'(n_f));

	// Sweep read address, head plus offset modulo depth
	assign issue  = cmd.sweep && (off_q <= CW'(follow_q));
	assign sw_sum = {1'b0, head_q} + (PW+1)'(off_q);
	always_comb begin
		if (sw_sum >= (PW+1)'(DEPTH)) begin
			sw_addr = PW'(sw_sum - (PW+1)'(DEPTH));
		end else begin
			sw_addr = PW'(sw_sum);
		end
	end
	assign rd_addr = cmd.start ? head_q : sw_addr;
	assign rd_en   = cmd.start || issue;

	// Divisor 2n, or 1 for a pass-through pixel
	assign divisor = (follow_q == '0) ? DW'(1) : {follow_q, 1'b0};

	// Products and restoring division decisions
	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			prod[c] = (FW+CB)'(follow_q) * (FW+CB)'(old_q[c]);
			qbit[c] = (num_q[c] >= dsh_q);
		end
	end

	assign sts.emit       = emit_c;
	assign sts.use_total  = use_total_q;
	assign sts.sweep_done = !(off_q <= CW'(follow_q)) && !rvld_q;
	assign sts.div_done   = (step_q == KW'(CB - 1));
	assign sts.out_free   = !out_valid_q || out_ready;

	// Store write and registered read
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			mem[tail_q] <= in_pix;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Control registers: config, pointers, fill count, sweep and step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blur_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			last_q      <= 1'b0;
			off_q       <= '0;
			rvld_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				blur_q <= blur_amount;
			end
			if (cmd.load_item) begin
				tail_q  <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + PW'(1);
				count_q <= count_q + CW'(1);
				last_q  <= row_end;
			end
			if (cmd.start) begin
				off_q <= CW'(1);
			end else if (issue) begin
				off_q <= off_q + CW'(1);
			end
			rvld_q <= issue;
			if (cmd.mul) begin
				step_q <= '0;
			end else if (cmd.div) begin
				step_q <= step_q + KW'(1);
			end
			// output transfer and drop of the oldest pixel
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
				head_q      <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + PW'(1);
				count_q     <= count_m1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Running sums of the pending pixels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_q <= '0;
		end else begin
			for (int c = 0; c < NCH; c++) begin
				if (cmd.load_item) begin
					tot_q[c] <= tot_q[c] + SW'(in_pix[c]);
				end else if (cmd.out_load) begin
					tot_q[c] <= tot_q[c] - SW'(old_q[c]);
				end
			end
		end
	end

	// Window sum, numerator and quotient
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			follow_q    <= follow_c;
			done_q      <= last_q && (follow_c == '0);
			use_total_q <= (CW'(follow_c) == count_m1);
		end
		for (int c = 0; c < NCH; c++) begin
			if (cmd.start) begin
				acc_q[c] <= '0;
			end else if (cmd.cap_old && use_total_q) begin
				acc_q[c] <= tot_q[c] - SW'(rd_data_q[c]);
			end else if (rvld_q) begin
				acc_q[c] <= acc_q[c] + SW'(rd_data_q[c]);
			end
			if (cmd.mul) begin
				// a pass-through pixel is its own value over one
				if (follow_q == '0) begin
					num_q[c] <= NW'(old_q[c]);
				end else begin
					num_q[c] <= NW'(prod[c]) + NW'(acc_q[c]);
				end
			end else if (cmd.div) begin
				if (qbit[c]) begin
					num_q[c] <= num_q[c] - dsh_q;
				end
				quo_q[c] <= CB'({quo_q[c], qbit[c]});
			end
		end
		if (cmd.cap_old) begin
			old_q <= rd_data_q;
		end
		if (cmd.mul) begin
			dsh_q <= NW'(divisor) << (CB - 1);
		end else if (cmd.div) begin
			dsh_q <= dsh_q >> 1;
		end
		if (cmd.out_load) begin
			out_q      <= quo_q;
			out_done_q <= done_q;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = out_q[0];
	assign green_out = out_q[1];
	assign blue_out  = out_q[2];
	assign row_done  = out_done_q;

endmodule
